/* design/sca_pkg.sv */
// package for the size class segment allocator
// holds layout field widths, status codes and sequencer states; no dependencies
package sca_pkg;

    localparam int NUM_CLASSES    = 5;
    localparam int BANK_BYTES     = 8192;
    localparam int TOTAL_SEGMENTS = 256;
    localparam int NUM_REGS       = 5;

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int IDX_W   = $clog2(TOTAL_SEGMENTS);
    localparam int BOFF_W  = $clog2(BANK_BYTES);
    localparam int LAYOUT_W = 40;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_NULL    = 2'd2,
        ST_NOTUSED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_CLASS,
        S_A_SCAN,
        S_A_MUL,
        S_F_CLASS,
        S_F_START,
        S_F_DIV1,
        S_F_DIV2,
        S_F_MUL,
        S_F_CHECK,
        S_DONE
    } state_t;

endpackage

/* design/size_class_segment_allocator_core.sv */
// size class segment allocator, top level
// depends on sca_pkg
//
// usage: an input word on s_axis carries op, request_size, free_offset and
// free_bank; exactly one result word leaves on m_axis with status, bank and
// offset. the user must write class layouts on the cfg port while the block is
// idle; the block itself does not enforce this. one item is handled at a time:
// s_axis_tready is high only when the sequencer is idle and the output register
// is empty. allocate: the sequencer walks the classes in order, scans the flags
// of each class whose segment size fits until a free flag turns up, moves on when
// a class is exhausted, then takes a multiply step and a done step.
// free: class pick, class start sum, two restoring divisions, multiply, check
// and done.
// the flag store is a 256-bit register cleared at reset, so no clearing pass.
// a result waits in the output register while m_axis_tready is low; no new
// item is taken until it is delivered.
module size_class_segment_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[0], request_size[16:1], free_offset[29:17], free_bank[37:30], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], alloc_bank[9:2], alloc_offset[22:10], zero pad
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sca_pkg::LAYOUT_W-1:0]  cfg_data
);

    localparam int NC = sca_pkg::NUM_CLASSES;
    localparam int CW = sca_pkg::CLS_W;
    localparam int IW = sca_pkg::IDX_W;
    localparam int BW = sca_pkg::BOFF_W;

    logic [sca_pkg::LAYOUT_W-1:0] layout_reg [NC];
    logic [sca_pkg::TOTAL_SEGMENTS-1:0] used_reg;

    sca_pkg::state_t state_reg, state_next;
    logic              op_reg;
    logic [15:0]       size_reg;
    logic [12:0]       foff_reg;
    logic [7:0]        fbank_reg;
    logic [CW-1:0]     cls_reg, cls_next;
    logic [CW:0]       k_reg, k_next;
    logic [12:0]       acc_reg, acc_next;   // class start sum, can exceed store
    logic [8:0]        j_reg, j_next;
    // shared divider: quotient/remainder shift
    logic [15:0]       dq_reg, dq_next;
    logic [16:0]       dr_reg, dr_next;
    logic [4:0]        dstep_reg, dstep_next;
    logic [15:0]       q1_reg, q1_next;
    logic [31:0]       prod_reg, prod_next;
    logic              out_v_reg;
    logic [1:0]        o_st_reg;
    logic [7:0]        o_bank_reg;
    logic [12:0]       o_off_reg;

    logic [15:0] c_ss, c_cnt, c_fb, c_nb;
    logic [12:0] idx_w;
    logic [16:0] dr_sh;
    logic [15:0] div_d;
    logic        done_fire;

    assign c_ss  = layout_reg[cls_reg][15:0];
    assign c_cnt = {8'd0, layout_reg[cls_reg][23:16]};
    assign c_fb  = {8'd0, layout_reg[cls_reg][31:24]};
    assign c_nb  = {8'd0, layout_reg[cls_reg][39:32]};

    assign s_axis_tready = (state_reg == sca_pkg::S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, o_off_reg, o_bank_reg, o_st_reg};

    // divisor: first offset/segsize, then count/banks
    assign div_d = (state_reg == sca_pkg::S_F_DIV1) ? c_ss : c_nb;
    assign dr_sh = {dr_reg[15:0], dq_reg[15]};
    assign idx_w = acc_reg + {4'd0, j_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                layout_reg[i] <= '0;
            end
        end
        else if (cfg_we && cfg_index < sca_pkg::CFG_IDX_W'(NC))
        begin
            layout_reg[cfg_index[CW-1:0]] <= cfg_data;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sca_pkg::S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (!s_axis_tdata[0])
                        state_next = sca_pkg::S_A_CLASS;
                    else if (s_axis_tdata[37:30] == 8'd0 || s_axis_tdata[29:17] == 13'd0)
                        state_next = sca_pkg::S_DONE;
                    else
                        state_next = sca_pkg::S_F_CLASS;
                end
            end
            sca_pkg::S_A_CLASS:
            begin
                if (k_reg == (CW+1)'(NC))
                    state_next = sca_pkg::S_DONE;
                else if (size_reg <= layout_reg[k_reg[CW-1:0]][15:0])
                    state_next = sca_pkg::S_A_SCAN;
            end
            sca_pkg::S_A_SCAN:
            begin
                if ({7'd0, j_reg} >= c_cnt || idx_w >= 13'(sca_pkg::TOTAL_SEGMENTS))
                    state_next = sca_pkg::S_A_CLASS;
                else if (!used_reg[idx_w[IW-1:0]])
                    state_next = sca_pkg::S_A_MUL;
            end
            sca_pkg::S_A_MUL:   state_next = sca_pkg::S_DONE;
            sca_pkg::S_F_CLASS:
            begin
                if ({8'd0, fbank_reg} >= {8'd0, layout_reg[k_reg[CW-1:0]][31:24]}
                    || k_reg == '0)
                    state_next = sca_pkg::S_F_START;
            end
            sca_pkg::S_F_START:
            begin
                if ({1'b0, k_reg[CW-1:0]} == {1'b0, cls_reg})
                begin
                    if ({8'd0, fbank_reg} < c_fb)
                        state_next = sca_pkg::S_DONE;
                    else
                        state_next = sca_pkg::S_F_DIV1;
                end
            end
            sca_pkg::S_F_DIV1:
            begin
                if (dstep_reg == 5'd16)
                    state_next = sca_pkg::S_F_DIV2;
            end
            sca_pkg::S_F_DIV2:
            begin
                if (dstep_reg == 5'd16)
                    state_next = sca_pkg::S_F_MUL;
            end
            sca_pkg::S_F_MUL:   state_next = sca_pkg::S_F_CHECK;
            sca_pkg::S_F_CHECK: state_next = sca_pkg::S_DONE;
            sca_pkg::S_DONE:    state_next = sca_pkg::S_IDLE;
            default:            state_next = sca_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cls_next   = cls_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        j_next     = j_reg;
        dq_next    = dq_reg;
        dr_next    = dr_reg;
        dstep_next = dstep_reg;
        q1_next    = q1_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            sca_pkg::S_IDLE:
            begin
                k_next   = s_axis_tdata[0] ? (CW+1)'(NC-1) : '0;
                cls_next = '0;
                acc_next = '0;
                j_next   = '0;
            end
            sca_pkg::S_A_CLASS:
            begin
                if (k_reg != (CW+1)'(NC))
                begin
                    if (size_reg <= layout_reg[k_reg[CW-1:0]][15:0])
                    begin
                        cls_next = k_reg[CW-1:0];
                        j_next   = '0;
                    end
                    else
                    begin
                        acc_next = acc_reg + {5'd0, layout_reg[k_reg[CW-1:0]][23:16]};
                    end
                    k_next = k_reg + 1'b1;
                end
            end
            sca_pkg::S_A_SCAN:
            begin
                if ({7'd0, j_reg} >= c_cnt || idx_w >= 13'(sca_pkg::TOTAL_SEGMENTS))
                    acc_next = acc_reg + c_cnt[12:0];
                else if (used_reg[idx_w[IW-1:0]])
                    j_next = j_reg + 1'b1;
            end
            sca_pkg::S_A_MUL:
                prod_next = 32'(j_reg) * 32'(c_ss);
            sca_pkg::S_F_CLASS:
            begin
                if ({8'd0, fbank_reg} >= {8'd0, layout_reg[k_reg[CW-1:0]][31:24]})
                begin
                    cls_next = k_reg[CW-1:0];
                    k_next   = '0;
                end
                else if (k_reg != '0)
                    k_next = k_reg - 1'b1;
            end
            sca_pkg::S_F_START:
            begin
                if (k_reg[CW-1:0] != cls_reg)
                begin
                    acc_next = acc_reg + {5'd0, layout_reg[k_reg[CW-1:0]][23:16]};
                    k_next   = k_reg + 1'b1;
                end
                dq_next    = {3'd0, foff_reg};
                dr_next    = '0;
                dstep_next = '0;
            end
            sca_pkg::S_F_DIV1, sca_pkg::S_F_DIV2:
            begin
                if (dstep_reg == 5'd16)
                begin
                    // zero divisor gives a zero quotient
                    if (state_reg == sca_pkg::S_F_DIV1)
                    begin
                        q1_next = (div_d == 16'd0) ? 16'd0 : dq_reg;
                        dq_next = c_cnt;
                    end
                    else
                    begin
                        dq_next = (div_d == 16'd0) ? 16'd0 : dq_reg;
                    end
                    dr_next    = '0;
                    dstep_next = '0;
                end
                else
                begin
                    dstep_next = dstep_reg + 1'b1;
                    if (dr_sh >= {1'b0, div_d})
                    begin
                        dr_next = dr_sh - {1'b0, div_d};
                        dq_next = {dq_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        dr_next = dr_sh;
                        dq_next = {dq_reg[14:0], 1'b0};
                    end
                end
            end
            sca_pkg::S_F_MUL:
                prod_next = 32'(fbank_reg - c_fb[7:0]) * 32'(dq_reg);
            default: ;
        endcase
    end

    // flag index: class start + offset quotient + bank distance times count quotient
    logic [31:0] fidx;
    assign fidx = {19'd0, acc_reg} + {16'd0, q1_reg} + prod_reg;
    assign done_fire = (state_reg == sca_pkg::S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sca_pkg::S_IDLE;
            used_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
                out_v_reg <= 1'b0;
            if (state_reg == sca_pkg::S_A_SCAN && state_next == sca_pkg::S_A_MUL)
                used_reg[idx_w[IW-1:0]] <= 1'b1;
            if (state_reg == sca_pkg::S_F_CHECK && fidx < 32'(sca_pkg::TOTAL_SEGMENTS)
                && used_reg[fidx[IW-1:0]])
                used_reg[fidx[IW-1:0]] <= 1'b0;
            if (done_fire)
                out_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg   <= cls_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        j_reg     <= j_next;
        dq_reg    <= dq_next;
        dr_reg    <= dr_next;
        dstep_reg <= dstep_next;
        q1_reg    <= q1_next;
        prod_reg  <= prod_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg    <= s_axis_tdata[0];
            size_reg  <= s_axis_tdata[16:1];
            foff_reg  <= s_axis_tdata[29:17];
            fbank_reg <= s_axis_tdata[37:30];
            o_st_reg  <= s_axis_tdata[0] ? sca_pkg::ST_NULL : sca_pkg::ST_OOM;
            o_bank_reg <= '0;
            o_off_reg  <= '0;
        end
        unique case (state_reg)
            sca_pkg::S_A_MUL:
            begin
                o_st_reg   <= sca_pkg::ST_OK;
                o_bank_reg <= 8'(32'(j_reg) * 32'(c_ss) / sca_pkg::BANK_BYTES) + c_fb[7:0];
                o_off_reg  <= 13'(32'(j_reg) * 32'(c_ss) % sca_pkg::BANK_BYTES);
            end
            sca_pkg::S_F_START:
                o_st_reg <= sca_pkg::ST_NOTUSED;
            sca_pkg::S_F_CHECK:
            begin
                if (fidx < 32'(sca_pkg::TOTAL_SEGMENTS) && used_reg[fidx[IW-1:0]])
                    o_st_reg <= sca_pkg::ST_OK;
                else
                    o_st_reg <= sca_pkg::ST_NOTUSED;
            end
            default: ;
        endcase
    end

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != sca_pkg::S_IDLE) |-> !s_axis_tready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_done_sets_valid;
        @(posedge clk) disable iff (!rst_n)
        done_fire |=> m_axis_tvalid;
    endproperty
    a_done_sets_valid: assert property (p_done_sets_valid) else $error("result lost");

    property p_op_path;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == sca_pkg::S_A_SCAN) |-> !op_reg;
    endproperty
    a_op_path: assert property (p_op_path) else $error("free in alloc scan");

endmodule
